FILE: design/esam_pkg.sv
package esam_pkg;

  localparam int unsigned CfgAddrW = 5;

  // register byte addresses
  localparam logic [CfgAddrW-1:0] RegCountsPerRev = 5'd0;
  localparam logic [CfgAddrW-1:0] RegSpeedWindow  = 5'd4;
  localparam logic [CfgAddrW-1:0] RegRpmPerCount  = 5'd8;
  localparam logic [CfgAddrW-1:0] RegAngleStep    = 5'd12;
  localparam logic [CfgAddrW-1:0] RegCaptureTicks = 5'd16;

  localparam logic [15:0] CountsPerRevRst = 16'd2400;
  localparam logic [7:0]  SpeedWindowRst  = 8'd20;
  localparam logic [15:0] RpmPerCountRst  = 16'd3200;
  localparam logic [31:0] AngleStepRst    = 32'd11244198;
  localparam logic [31:0] CaptureTicksRst = 32'd6875000;

  // 0.10472 in q0.16
  localparam logic [12:0] RadsPerRpmQ16 = 13'd6863;

  localparam int unsigned DigitW = 4;

  typedef struct packed {
    logic [15:0] position_count;
    logic        start_capture;
  } esam_in_t;

  typedef struct packed {
    logic signed [31:0] angle_rad_q16;
    logic signed [27:0] speed_rpm_q8;
    logic signed [23:0] speed_rads_q8;
    logic               speed_updated;
    logic               capture_active;
  } esam_out_t;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StMul  = 4'b0010,
    StRads = 4'b0100,
    StOut  = 4'b1000
  } esam_state_e;

endpackage

FILE: design/esam_if.sv
interface esam_in_if;
  import esam_pkg::*;
  logic     valid;
  logic     ready;
  esam_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface esam_out_if;
  import esam_pkg::*;
  logic      valid;
  logic      ready;
  esam_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/encoder_speed_angle_meter.sv
// Encoder speed and angle meter. Each input word is one timer tick with the
// encoder position; one result word follows per tick. A new tick is accepted
// only after the previous one has loaded its result word. The angle product is
// formed by a digit-serial multiplier working 4 bits of the angle step per
// cycle, followed on a window end by the speed-to-rad/s product on the same
// kind of unit; the sequencer passes through StMul, then StRads on a window
// end, then StOut, which loads the output register.
// A result still waiting at the output holds the sequencer only when the next
// result is due to load. Registers must be written over the APB port only
// while no tick is in flight; the block itself does not enforce this.
module encoder_speed_angle_meter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [esam_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  esam_in_if.sink     in_if,
  esam_out_if.source  out_if
);
  import esam_pkg::*;

  logic [15:0] cpr_q;
  logic [7:0]  win_q;
  logic [15:0] rpc_q;
  logic [31:0] step_q, capt_q;

  logic [15:0] prev_q, wstart_q;
  logic [31:0] acc_q, ccnt_q;
  logic [7:0]  wcnt_q;
  logic signed [27:0] rpm_q;
  logic signed [23:0] rads_q;
  logic        copen_q, upd_q;
  esam_state_e st_q;
  esam_out_t   res_q;
  logic        ovalid_q;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q  <= CountsPerRevRst;
      win_q  <= SpeedWindowRst;
      rpc_q  <= RpmPerCountRst;
      step_q <= AngleStepRst;
      capt_q <= CaptureTicksRst;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        RegCountsPerRev: cpr_q  <= pwdata[15:0];
        RegSpeedWindow:  win_q  <= pwdata[7:0];
        RegRpmPerCount:  rpc_q  <= pwdata[15:0];
        RegAngleStep:    step_q <= pwdata;
        RegCaptureTicks: capt_q <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr)
      RegCountsPerRev: prdata = {16'd0, cpr_q};
      RegSpeedWindow:  prdata = {24'd0, win_q};
      RegRpmPerCount:  prdata = {16'd0, rpc_q};
      RegAngleStep:    prdata = step_q;
      RegCaptureTicks: prdata = capt_q;
      default:         prdata = '0;
    endcase
  end

  // unwrap and window logic
  logic signed [17:0] rev, half, d, dw, p1, p;
  logic [7:0]  wnext;
  logic        wend, acc_in;
  logic [31:0] acc_next;

  assign acc_in = in_if.valid && in_if.ready;
  always_comb begin
    rev  = 18'(cpr_q);
    half = 18'(cpr_q >> 1);
    d = 18'(in_if.data.position_count) - 18'(prev_q);
    if (d >= half) dw = d - rev;
    else if (d <= -half) dw = d + rev;
    else dw = d;
    p1 = 18'(in_if.data.position_count) - 18'(wstart_q);
    if (p1 >= half) p1 = p1 - rev;
    if (p1 <= -half) p = p1 + rev;
    else p = p1;
    wnext = wcnt_q + 8'd1;
    wend  = (wnext >= win_q);
    acc_next = acc_q + 32'(dw);
  end

  // rpm product is narrow: 18x16, formed combinationally, then saturate
  logic signed [34:0] rpm_full;
  logic signed [27:0] rpm_sat;
  assign rpm_full = p * $signed({1'b0, rpc_q});
  assign rpm_sat = (rpm_full > 35'sd134217727) ? 28'sh7FFFFFF :
                   (rpm_full < -35'sd134217728) ? 28'sh8000000 : 28'(rpm_full);

  // serial multipliers
  logic        m1_done, m2_done, m2_start;
  logic signed [63:0] m1_p;
  logic signed [40:0] m2_p;
  logic signed [27:0] rpm_hold_q;

  esam_sermul #(.AW(32), .BW(32)) u_angle_mul (
    .clk_i, .rst_ni, .start_i(acc_in), .a_i($signed(acc_next)), .b_i(step_q),
    .done_o(m1_done), .p_o(m1_p)
  );

  esam_sermul #(.AW(28), .BW(13)) u_rads_mul (
    .clk_i, .rst_ni, .start_i(m2_start), .a_i(rpm_hold_q), .b_i(RadsPerRpmQ16),
    .done_o(m2_done), .p_o(m2_p)
  );

  assign m2_start = (st_q == StMul) && m1_done;

  logic [63:0] ang_raw;
  logic signed [41:0] rads_raw;
  logic signed [25:0] rads_sh;
  logic [31:0] angle_q;
  logic        out_load;
  assign ang_raw  = (64'd0 - 64'(m1_p)) + 64'h8000;
  assign rads_raw = 42'(m2_p) + 42'sd32768;
  assign rads_sh  = 26'(rads_raw >>> 16);

  // output register loads when empty or being emptied
  assign out_load    = (st_q == StOut) && (!ovalid_q || out_if.ready);
  assign in_if.ready = (st_q == StIdle);

  // tick sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      prev_q <= '0; wstart_q <= '0; acc_q <= '0; wcnt_q <= '0;
      rpm_q <= '0; rads_q <= '0; copen_q <= 1'b0; ccnt_q <= '0;
      upd_q <= 1'b0; ovalid_q <= 1'b0;
      rpm_hold_q <= '0; angle_q <= '0; res_q <= '0;
    end else begin
      if (out_load) ovalid_q <= 1'b1;
      else if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      case (st_q)
        StIdle: if (acc_in) begin
          prev_q <= in_if.data.position_count;
          acc_q  <= acc_next;
          upd_q  <= wend;
          if (wend) begin
            wcnt_q <= '0;
            wstart_q <= in_if.data.position_count;
            rpm_hold_q <= rpm_sat;
          end else begin
            wcnt_q <= wnext;
          end
          if (in_if.data.start_capture || copen_q) begin
            if (ccnt_q + 32'd1 == capt_q) begin
              copen_q <= 1'b0; ccnt_q <= '0;
            end else begin
              copen_q <= 1'b1; ccnt_q <= ccnt_q + 32'd1;
            end
          end else begin
            ccnt_q <= '0;
          end
          st_q <= StMul;
        end
        StMul: if (m1_done) begin
          angle_q <= ang_raw[47:16];
          st_q <= upd_q ? StRads : StOut;
        end
        StRads: if (m2_done) begin
          rpm_q <= rpm_hold_q;
          rads_q <= (rads_sh > 26'sd8388607) ? 24'sh7FFFFF :
                    (rads_sh < -26'sd8388608) ? 24'sh800000 : 24'(rads_sh);
          st_q <= StOut;
        end
        StOut: if (out_load) begin
          res_q.angle_rad_q16  <= $signed(angle_q);
          res_q.speed_rpm_q8   <= rpm_q;
          res_q.speed_rads_q8  <= rads_q;
          res_q.speed_updated  <= upd_q;
          res_q.capture_active <= copen_q;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data  = res_q;

  // result only shown after the sequencer finished a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(st_q == StOut)) else $error("result without tick");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("result changed while waiting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("state not one-hot");
endmodule

FILE: design/esam_sermul.sv
// signed a times unsigned b, b taken DigitW bits a cycle from the low end
module esam_sermul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [AW-1:0] a_i,
  input  logic        [BW-1:0] b_i,
  output logic                 done_o,
  output logic signed [AW+BW-1:0] p_o
);
  import esam_pkg::*;

  localparam int unsigned Steps = (BW + DigitW - 1) / DigitW;
  localparam int unsigned BPad  = Steps * DigitW;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic signed [AW-1:0]     a_q;
  logic [BPad-1:0]          b_q;
  logic signed [AW+BPad-1:0] acc_q;
  logic [CntW-1:0]          cnt_q;
  logic                     busy_q, done_q;
  logic signed [AW+DigitW:0] part, sum;
  logic [AW+BPad+DigitW:0]  acc_w;

  // one digit partial product
  assign part = a_q * $signed({1'b0, b_q[DigitW-1:0]});

  // add into the high part, low bits carried along
  assign sum   = $signed(acc_q[AW+BPad-1:BPad]) + part;
  assign acc_w = {sum, acc_q[BPad-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Steps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // accumulate high half, shift right one digit a step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= BPad'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= b_q >> DigitW;
      acc_q <= acc_w[AW+BPad+DigitW-1:DigitW];
    end
  end

  assign done_o = done_q;
  assign p_o    = (AW+BW)'(acc_q);
endmodule

FILE: dv/esam_checker.sv
module esam_checker
  import esam_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  esam_in_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  esam_out_t  out_data_i,
  // register writes seen on the apb port
  input  logic       psel_i,
  input  logic       penable_i,
  input  logic       pwrite_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [31:0] pwdata_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // configuration copy
  logic [15:0] cpr;
  logic [7:0]  win_len;
  logic [15:0] rpm_gain;
  logic [31:0] ang_step;
  logic [31:0] cap_len;

  // meter state copy
  logic [15:0] prev_pos;
  logic [31:0] angle_acc;
  logic [15:0] win_pos;
  logic [7:0]  win_cnt;
  logic signed [27:0] held_rpm;
  logic signed [23:0] held_rads;
  logic        cap_open;
  logic [31:0] cap_cnt;

  esam_out_t tick_results_q[$];

  assign pending_o = tick_results_q.size();

  function automatic esam_out_t meter_tick(esam_in_t w);
    esam_out_t r;
    int signed half;
    int signed d;
    int signed p;
    longint signed rpm;
    longint signed rads;
    longint signed prod;
    logic [63:0] pu;
    half = int'(cpr) / 2;
    // angle unwrap and accumulate
    d = int'(w.position_count) - int'(prev_pos);
    if (d >= half) d -= int'(cpr);
    else if (d <= -half) d += int'(cpr);
    prev_pos = w.position_count;
    angle_acc = angle_acc + d;
    prod = longint'($signed(angle_acc)) * longint'({32'd0, ang_step});
    pu = 64'd0 - 64'(prod) + 64'h8000;
    r.angle_rad_q16 = pu[47:16];
    r.speed_updated = 1'b0;
    // speed window
    win_cnt = win_cnt + 8'd1;
    if (win_cnt >= win_len) begin
      p = int'(w.position_count) - int'(win_pos);
      win_pos = w.position_count;
      if (p >= half) p -= int'(cpr);
      if (p <= -half) p += int'(cpr);
      rpm = longint'(p) * longint'(rpm_gain);
      if (rpm > 134217727) rpm = 134217727;
      if (rpm < -134217728) rpm = -134217728;
      rads = (rpm * 6863 + 32768) >>> 16;
      if (rads > 8388607) rads = 8388607;
      if (rads < -8388608) rads = -8388608;
      held_rpm = rpm[27:0];
      held_rads = rads[23:0];
      win_cnt = 8'd0;
      r.speed_updated = 1'b1;
    end
    // capture window
    if (w.start_capture) cap_open = 1'b1;
    if (cap_open) begin
      cap_cnt = cap_cnt + 32'd1;
      if (cap_cnt == cap_len) begin
        cap_open = 1'b0;
        cap_cnt = 32'd0;
      end
    end else begin
      cap_cnt = 32'd0;
    end
    r.speed_rpm_q8 = held_rpm;
    r.speed_rads_q8 = held_rads;
    r.capture_active = cap_open;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    esam_out_t e;
    if (!rst_ni) begin
      cpr = CountsPerRevRst;
      win_len = SpeedWindowRst;
      rpm_gain = RpmPerCountRst;
      ang_step = AngleStepRst;
      cap_len = CaptureTicksRst;
      prev_pos = '0;
      angle_acc = '0;
      win_pos = '0;
      win_cnt = '0;
      held_rpm = '0;
      held_rads = '0;
      cap_open = 1'b0;
      cap_cnt = '0;
      fail_count_o = 0;
      tick_results_q.delete();
    end else begin
      // register write
      if (psel_i && penable_i && pwrite_i) begin
        case (paddr_i)
          RegCountsPerRev: cpr = pwdata_i[15:0];
          RegSpeedWindow:  win_len = pwdata_i[7:0];
          RegRpmPerCount:  rpm_gain = pwdata_i[15:0];
          RegAngleStep:    ang_step = pwdata_i;
          RegCaptureTicks: cap_len = pwdata_i;
          default: ;
        endcase
      end
      // result compare
      if (out_valid_i && out_ready_i) begin
        if (tick_results_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count_o++;
        end else begin
          e = tick_results_q.pop_front();
          if (out_data_i.angle_rad_q16 !== e.angle_rad_q16) begin
            $error("angle_rad_q16 exp %0d got %0d", e.angle_rad_q16, out_data_i.angle_rad_q16);
            fail_count_o++;
          end
          if (out_data_i.speed_rpm_q8 !== e.speed_rpm_q8) begin
            $error("speed_rpm_q8 exp %0d got %0d", e.speed_rpm_q8, out_data_i.speed_rpm_q8);
            fail_count_o++;
          end
          if (out_data_i.speed_rads_q8 !== e.speed_rads_q8) begin
            $error("speed_rads_q8 exp %0d got %0d", e.speed_rads_q8,
                   out_data_i.speed_rads_q8);
            fail_count_o++;
          end
          if (out_data_i.speed_updated !== e.speed_updated) begin
            $error("speed_updated exp %0b got %0b", e.speed_updated,
                   out_data_i.speed_updated);
            fail_count_o++;
          end
          if (out_data_i.capture_active !== e.capture_active) begin
            $error("capture_active exp %0b got %0b", e.capture_active,
                   out_data_i.capture_active);
            fail_count_o++;
          end
        end
      end
      // tick accepted
      if (in_valid_i && in_ready_i) tick_results_q.push_back(meter_tick(in_data_i));
    end
  end
endmodule

FILE: dv/tb_encoder_speed_angle_meter.sv
module tb_encoder_speed_angle_meter;
  import esam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count;
  int pending;
  logic [15:0] cur_cpr = CountsPerRevRst;
  logic [15:0] cur_pos = '0;

  esam_in_if in_if ();
  esam_out_if out_if ();

  encoder_speed_angle_meter DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  esam_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_i(in_if.ready), .in_data_i(in_if.data),
    .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  // apb write: setup then access
  task automatic reg_write(logic [CfgAddrW-1:0] a, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= v; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == RegCountsPerRev) cur_cpr = v[15:0];
  endtask

  // stop sending, wait until all results are taken, then idle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // valid stays high into the next word when there is no gap
  task automatic send_word(logic [15:0] pos, logic sc, bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{position_count: pos, start_capture: sc};
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (out_if.valid && out_if.ready) out_if.ready <= 1'b0;
      else if (!out_if.ready) begin
        repeat ($urandom_range(0, 6)) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end
    end
  end

  // random motion phase: mostly plausible steps, some jumps
  task automatic run_phase(int n, bit no_gap);
    int step;
    int unsigned k;
    logic [15:0] p;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        step = $urandom_range(0, 2 * 40) - 40;
        if (cur_cpr > 1) p = 16'((int'(cur_pos) + step + int'(cur_cpr)) % int'(cur_cpr));
        else p = 16'(int'(cur_pos) + step);
      end else if (k < 9) begin
        p = 16'($urandom_range(0, cur_cpr > 0 ? cur_cpr - 1 : 0));
      end else begin
        p = 16'($urandom());
      end
      cur_pos = p;
      send_word(p, ($urandom_range(0, 15) == 0), no_gap);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, half-revolution steps, capture
    reg_write(RegCaptureTicks, 32'd3);
    send_word(16'd0, 1'b1, 1'b0);
    send_word(16'd1200, 1'b0, 1'b0);
    send_word(16'd0, 1'b1, 1'b0);
    send_word(16'd2399, 1'b0, 1'b0);
    send_word(16'd1199, 1'b0, 1'b0);
    send_word(16'd1201, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'd0, 1'b1, 1'b0);
    for (int i = 0; i < 14; i++) send_word(16'(i * 90), 1'b0, 1'b0);
    drain();
    // extremes of the registers
    reg_write(RegCountsPerRev, 32'd65535);
    reg_write(RegSpeedWindow, 32'd1);
    reg_write(RegRpmPerCount, 32'hFFFF);
    reg_write(RegAngleStep, 32'hFFFF_FFFF);
    reg_write(RegCaptureTicks, 32'd1);
    send_word(16'd32767, 1'b1, 1'b0);
    send_word(16'd0, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'd32768, 1'b0, 1'b0);
    drain();
    cur_cpr = 16'd65535;
    run_phase(250, 1'b0);
    drain();
    reg_write(RegCountsPerRev, 32'd2);
    reg_write(RegSpeedWindow, 32'd0);
    reg_write(RegRpmPerCount, 32'd0);
    reg_write(RegAngleStep, 32'd0);
    reg_write(RegCaptureTicks, 32'd0);
    run_phase(150, 1'b1);
    drain();
    reg_write(RegCountsPerRev, 32'd2400);
    reg_write(RegSpeedWindow, 32'd255);
    reg_write(RegRpmPerCount, 32'd3200);
    reg_write(RegAngleStep, 32'd11244198);
    reg_write(RegCaptureTicks, 32'd20);
    run_phase(550, 1'b0);
    drain();
    reg_write(RegSpeedWindow, 32'd4);
    reg_write(RegCountsPerRev, 32'd1001);
    reg_write(RegRpmPerCount, 32'($urandom_range(0, 65535)));
    reg_write(RegAngleStep, $urandom());
    reg_write(RegCaptureTicks, 32'd7);
    run_phase(300, 1'b0);
    // window shortened below the running count
    drain();
    reg_write(RegSpeedWindow, 32'd2);
    run_phase(250, 1'b0);
    drain();
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

FILE: sim.f
design/esam_pkg.sv
design/esam_if.sv
design/esam_sermul.sv
design/encoder_speed_angle_meter.sv
dv/esam_checker.sv
dv/tb_encoder_speed_angle_meter.sv
